// File: src/sm4_block_cipher_ecb_cbc_unit_defines.svh
// Assertion macros for the SM4 cipher unit.
// Builds that define NO_ASSERTIONS get empty bodies.
`ifndef SM4_BLOCK_CIPHER_ECB_CBC_UNIT_DEFINES_SVH
`define SM4_BLOCK_CIPHER_ECB_CBC_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define SM4_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("SM4 unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SM4_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("SM4 unit: next-cycle check failed");

`else

`define SM4_ASSERT_IMPLY(lbl, ck, rs, ante, cons)
`define SM4_ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

// File: src/sm4_pkg.sv
`default_nettype none

package sm4_pkg;

  // Round count and the index width of the round key store.
  localparam int ROUNDS = 32;
  localparam int RIDX_W = $clog2(ROUNDS);

  typedef logic [RIDX_W-1:0] ridx_t;

  // System parameter FK of the key schedule.
  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  // Byte substitution table.
  localparam logic [7:0] SBOX [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  // One input item.
  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;
    logic        last_block;
  } blk_item_t;

  // One result item.
  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        last_out;
  } res_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  start;    // load an accepted item
    logic  round;    // run one cipher round
    logic  finish;   // move the cipher state to the result register
    logic  kload;    // load the key schedule words from the key registers
    logic  kstep;    // run one key schedule round and store its round key
    ridx_t kidx;     // key schedule round number
    ridx_t rk_addr;  // round key read address for the next cycle
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic res_valid;
  } dp_status_t;

  // Four parallel table lookups.
  function automatic logic [31:0] subst_word(input logic [31:0] a);
    return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  // Round transform of the cipher: rotations by 2, 10, 18 and 24.
  function automatic logic [31:0] t_cipher(input logic [31:0] z);
    logic [31:0] b;
    b = subst_word(z);
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
             ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
  endfunction

  // Round transform of the key schedule: rotations by 13 and 23.
  function automatic logic [31:0] t_key(input logic [31:0] z);
    logic [31:0] b;
    b = subst_word(z);
    return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

  // CK word i: byte j is (4*i + j) * 7 modulo 256.
  function automatic logic [31:0] ck_word(input ridx_t i);
    logic [31:0] w;
    logic [7:0]  v;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      v = {1'b0, i, 2'(j)};
      w[31-8*j -: 8] = {v[4:0], 3'b000} - v;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// File: src/sm4_ctrl.sv
`default_nettype none

module sm4_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                blk_valid,
  input  logic                res_stall,
  input  logic                key_write,
  input  logic                dec,
  input  sm4_pkg::dp_status_t status,
  output logic                blk_stall,
  output sm4_pkg::dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_KLOAD = 5'b00001,
    ST_KEXP  = 5'b00010,
    ST_IDLE  = 5'b00100,
    ST_ROUND = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  localparam sm4_pkg::ridx_t LAST = sm4_pkg::ridx_t'(sm4_pkg::ROUNDS - 1);
  localparam sm4_pkg::ridx_t ONE  = sm4_pkg::ridx_t'(1);

  state_t         state, state_next;
  sm4_pkg::ridx_t cnt, cnt_next;
  logic           out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free  = !status.res_valid || !res_stall;
  assign blk_stall = (state != ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    cmd         = '0;
    cmd.kidx    = cnt;
    cmd.rk_addr = dec ? LAST : '0;
    case (state)
      ST_KLOAD: begin
        cmd.kload  = 1'b1;
        cnt_next   = '0;
        state_next = ST_KEXP;
      end
      ST_KEXP: begin
        cmd.kstep = 1'b1;
        cnt_next  = cnt + ONE;
        if (cnt == LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (blk_valid) begin
          cmd.start  = 1'b1;
          cnt_next   = '0;
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        // Fetch the key of the following round ahead of time through the registered read port.
        cmd.rk_addr = dec ? (LAST - cnt - ONE) : (cnt + ONE);
        cnt_next    = cnt + ONE;
        if (cnt == LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_KLOAD;
      end
    endcase
    // A new key restarts the key schedule.
    if (key_write) begin
      state_next = ST_KLOAD;
    end
  end

  // State and round counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_KLOAD;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// File: src/sm4_dp.sv
`default_nettype none

module sm4_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  sm4_pkg::dp_cmd_t     cmd,
  input  sm4_pkg::blk_item_t   blk,
  input  logic                 res_stall,
  input  logic [63:0]          key_high,
  input  logic [63:0]          key_low,
  input  logic [63:0]          iv_high,
  input  logic [63:0]          iv_low,
  input  logic                 dec,
  input  logic                 cbc,
  output logic                 res_valid,
  output sm4_pkg::res_item_t   res,
  output sm4_pkg::dp_status_t  status
);

  // Round key store, written by the key schedule and read once per round.
  logic [31:0]  rk_mem [sm4_pkg::ROUNDS];
  logic [31:0]  rk_rdata;

  // Key schedule words and cipher state words.
  logic [31:0]  k0, k1, k2, k3;
  logic [31:0]  x0, x1, x2, x3;
  logic [31:0]  k_new, x_new;

  // Chaining block and per-item control kept for the end of the item.
  logic [127:0] chain;
  logic [127:0] chain_eff;
  logic [127:0] post_xor;
  logic [127:0] blk_word;
  logic [127:0] cipher_in;
  logic [127:0] result;
  logic         enc_chain;
  logic         last_flag;

  assign k_new = k0 ^ sm4_pkg::t_key(k1 ^ k2 ^ k3 ^ sm4_pkg::ck_word(cmd.kidx));
  assign x_new = x0 ^ sm4_pkg::t_cipher(x1 ^ x2 ^ x3 ^ rk_rdata);

  // A first block takes its chaining value from the IV registers.
  assign blk_word  = {blk.block_high, blk.block_low};
  assign chain_eff = blk.first_block ? {iv_high, iv_low} : chain;
  assign cipher_in = (cbc && !dec) ? (blk_word ^ chain_eff) : blk_word;

  // The final state is read out in reverse word order.
  assign result = {x3, x2, x1, x0} ^ post_xor;

  assign status.res_valid = res_valid;

  // Round key store with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.kstep) begin
      rk_mem[cmd.kidx] <= k_new;
    end
    rk_rdata <= rk_mem[cmd.rk_addr];
  end

  // Key schedule word shifter.
  always_ff @(posedge clk) begin
    if (cmd.kload) begin
      k0 <= key_high[63:32] ^ sm4_pkg::FK0;
      k1 <= key_high[31:0]  ^ sm4_pkg::FK1;
      k2 <= key_low[63:32]  ^ sm4_pkg::FK2;
      k3 <= key_low[31:0]   ^ sm4_pkg::FK3;
    end else if (cmd.kstep) begin
      k0 <= k1;
      k1 <= k2;
      k2 <= k3;
      k3 <= k_new;
    end
  end

  // Cipher state: loaded from the item, then one round per cycle.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x0        <= cipher_in[127:96];
      x1        <= cipher_in[95:64];
      x2        <= cipher_in[63:32];
      x3        <= cipher_in[31:0];
      post_xor  <= (cbc && dec) ? chain_eff : '0;
      enc_chain <= cbc && !dec;
      last_flag <= blk.last_block;
    end else if (cmd.round) begin
      x0 <= x1;
      x1 <= x2;
      x2 <= x3;
      x3 <= x_new;
    end
  end

  // Chaining block: CBC decryption keeps the input, CBC encryption the output; else a first block loads the IV.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= '0;
    end else if (cmd.start) begin
      if (cbc && dec) begin
        chain <= blk_word;
      end else if (blk.first_block) begin
        chain <= {iv_high, iv_low};
      end
    end else if (cmd.finish && enc_chain) begin
      chain <= result;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res.result_high <= result[127:64];
      res.result_low  <= result[63:0];
      res.last_out    <= last_flag;
    end
  end

endmodule

`default_nettype wire

// File: src/sm4_block_cipher_ecb_cbc_unit.sv
`default_nettype none

// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------
// blk      | blk_valid, blk_stall | block_high, block_low, first_block, last_block
// res      | res_valid, res_stall | result_high, result_low, last_out
// config   | APB, 64-bit data     | key, IV, decrypt_mode, chaining_mode at 8*i
//
// An item is loaded, runs 32 rounds through the single round unit with a key
// read from the round key store each cycle, and is then written to the result
// register. A key write, and reset, run the key schedule: a load and 32 rounds,
// during which blk_stall is high. A result waiting on res_stall does not hold
// up the next item until that item is finished.

`include "sm4_block_cipher_ecb_cbc_unit_defines.svh"

module sm4_block_cipher_ecb_cbc_unit (
  input  logic                clk,
  input  logic                rst,
  // Input items
  input  logic                blk_valid,
  output logic                blk_stall,
  input  sm4_pkg::blk_item_t  blk,
  // Result items
  output logic                res_valid,
  input  logic                res_stall,
  output sm4_pkg::res_item_t  res,
  // Configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);

  localparam logic [2:0] REG_KEY_HIGH      = 3'd0;
  localparam logic [2:0] REG_KEY_LOW       = 3'd1;
  localparam logic [2:0] REG_IV_HIGH       = 3'd2;
  localparam logic [2:0] REG_IV_LOW        = 3'd3;
  localparam logic [2:0] REG_DECRYPT_MODE  = 3'd4;
  localparam logic [2:0] REG_CHAINING_MODE = 3'd5;

  logic [63:0]         key_high, key_low, iv_high, iv_low;
  logic                decrypt_mode, chaining_mode;
  logic [2:0]          reg_idx;
  logic                wr_en;
  logic                key_write;
  sm4_pkg::dp_cmd_t    cmd;
  sm4_pkg::dp_status_t status;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[5:3];
  assign wr_en     = psel && penable && pwrite && pready;
  assign key_write = wr_en && (reg_idx == REG_KEY_HIGH || reg_idx == REG_KEY_LOW);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high      <= '0;
      key_low       <= '0;
      iv_high       <= '0;
      iv_low        <= '0;
      decrypt_mode  <= 1'b0;
      chaining_mode <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_KEY_HIGH:      key_high      <= pwdata;
        REG_KEY_LOW:       key_low       <= pwdata;
        REG_IV_HIGH:       iv_high       <= pwdata;
        REG_IV_LOW:        iv_low        <= pwdata;
        REG_DECRYPT_MODE:  decrypt_mode  <= pwdata[0];
        REG_CHAINING_MODE: chaining_mode <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      REG_KEY_HIGH:      prdata = key_high;
      REG_KEY_LOW:       prdata = key_low;
      REG_IV_HIGH:       prdata = iv_high;
      REG_IV_LOW:        prdata = iv_low;
      REG_DECRYPT_MODE:  prdata = {63'd0, decrypt_mode};
      REG_CHAINING_MODE: prdata = {63'd0, chaining_mode};
      default:           prdata = '0;
    endcase
  end

  // Sequencer.
  sm4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .blk_valid (blk_valid),
    .res_stall (res_stall),
    .key_write (key_write),
    .dec       (decrypt_mode),
    .status    (status),
    .blk_stall (blk_stall),
    .cmd       (cmd)
  );

  // Key schedule, round unit, chaining and result register.
  sm4_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .blk       (blk),
    .res_stall (res_stall),
    .key_high  (key_high),
    .key_low   (key_low),
    .iv_high   (iv_high),
    .iv_low    (iv_low),
    .dec       (decrypt_mode),
    .cbc       (chaining_mode),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  // A new key blocks input while the schedule is rebuilt.
  `SM4_ASSERT_NEXT(a_key_write_stalls, clk, rst, key_write, blk_stall)
  // The engine takes one item at a time.
  `SM4_ASSERT_NEXT(a_accept_then_busy, clk, rst, blk_valid && !blk_stall, blk_stall)
  // A result appears only after the sequencer finished an item.
  `SM4_ASSERT_IMPLY(a_result_from_finish, clk, rst, $rose(res_valid), $past(cmd.finish))

endmodule

`default_nettype wire

// File: bench/sm4_block_cipher_ecb_cbc_unit_tb.sv
`timescale 1ns / 1ps

module sm4_block_cipher_ecb_cbc_unit_tb;

  // Register map, one 64-bit register every 8 bytes.
  typedef enum logic [2:0] {
    REG_KEY_HIGH,
    REG_KEY_LOW,
    REG_IV_HIGH,
    REG_IV_LOW,
    REG_DECRYPT_MODE,
    REG_CHAINING_MODE,
    REG_SPARE_6,
    REG_SPARE_7
  } reg_idx_e;

  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  // Key schedule system parameter.
  localparam logic [31:0] SYS_FK0 = 32'ha3b1bac6;
  localparam logic [31:0] SYS_FK1 = 32'h56aa3350;
  localparam logic [31:0] SYS_FK2 = 32'h677d9197;
  localparam logic [31:0] SYS_FK3 = 32'hb27022dc;

  // Published example: key and plaintext are the same 128-bit value.
  localparam logic [127:0] SAMPLE_TEXT = 128'h0123456789abcdeffedcba9876543210;
  localparam logic [127:0] SAMPLE_CIPHER = 128'h681edf34d206965e86b3e94f536e4246;

  // Byte substitution table, entry i at bits [8*i +: 8].
  localparam logic [0:2047] SUBST_TABLE = {
    128'hd690e9fe_cce13db7_16b614c2_28fb2c05,
    128'h2b679a76_2abe04c3_aa441326_49860699,
    128'h9c4250f4_91ef987a_33540b43_edcfac62,
    128'he4b31ca9_c908e895_80df94fa_758f3fa6,
    128'h4707a7fc_f37317ba_83593c19_e6854fa8,
    128'h686b81b2_7164da8b_f8eb0f4b_70569d35,
    128'h1e240e5e_6358d1a2_25227c3b_01217887,
    128'hd4004657_9fd32752_4c3602e7_a0c4c89e,
    128'heabf8ad2_40c738b5_a3f7f2ce_f96115a1,
    128'he0ae5da4_9b341a55_ad933230_f58cb1e3,
    128'h1df6e22e_8266ca60_c02923ab_0d534e6f,
    128'hd5db3745_defd8e2f_03ff6a72_6d6c5b51,
    128'h8d1baf92_bbddbc7f_11d95c41_1f105ad8,
    128'h0ac13188_a5cd7bbd_2d74d012_b8e5b4b0,
    128'h8969974a_0c96777e_65b9f109_c56ec684,
    128'h18f07dec_3adc4d20_79ee5f3e_d7cb3948
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                blk_valid = 1'b0;
  logic                blk_stall;
  sm4_pkg::blk_item_t  blk = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  sm4_pkg::res_item_t  res;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [5:0]          paddr = '0;
  logic [63:0]         pwdata = '0;
  logic [63:0]         prdata;
  logic                pready;

  sm4_block_cipher_ecb_cbc_unit dut (
    .clk(clk),
    .rst(rst),
    .blk_valid(blk_valid),
    .blk_stall(blk_stall),
    .blk(blk),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the configuration and of the cipher state.
  logic [63:0]  key_word_hi, key_word_lo, iv_word_hi, iv_word_lo;
  logic         dec_on, cbc_on;
  logic [31:0]  round_key [32];
  logic [127:0] chain_word;

  sm4_pkg::blk_item_t blocks_to_send [$];
  sm4_pkg::res_item_t blocks_due [$];
  int        blocks_sent = 0;
  int        blocks_taken = 0;
  int        results_seen = 0;
  int        fault_count = 0;
  bit        throttle_on = 1'b1;
  int        gap_left = 0;
  int        hold_left = 0;
  int        idle_cycles = 0;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    logic [31:0] r;
    for (int k = 0; k < 4; k++) r[8*k +: 8] = SUBST_TABLE[8*w[8*k +: 8] +: 8];
    return r;
  endfunction

  function automatic logic [31:0] mix_data(input logic [31:0] z);
    logic [31:0] b;
    b = sub_word(z);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  function automatic logic [31:0] mix_key(input logic [31:0] z);
    logic [31:0] b;
    b = sub_word(z);
    return b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  // Byte j of constant word i is (4*i + j) * 7, truncated to 8 bits.
  function automatic logic [31:0] ck_const(input int i);
    logic [31:0] w;
    for (int j = 0; j < 4; j++) w[31-8*j -: 8] = 8'((4*i + j) * 7);
    return w;
  endfunction

  function automatic void expand_key();
    logic [31:0] k0, k1, k2, k3, nk;
    k0 = key_word_hi[63:32] ^ SYS_FK0;
    k1 = key_word_hi[31:0] ^ SYS_FK1;
    k2 = key_word_lo[63:32] ^ SYS_FK2;
    k3 = key_word_lo[31:0] ^ SYS_FK3;
    for (int r = 0; r < 32; r++) begin
      nk = k0 ^ mix_key(k1 ^ k2 ^ k3 ^ ck_const(r));
      k0 = k1;
      k1 = k2;
      k2 = k3;
      k3 = nk;
      round_key[r] = nk;
    end
  endfunction

  function automatic logic [127:0] sm4_transform(input logic [127:0] d, input bit inverse);
    logic [31:0] w0, w1, w2, w3, rk, nx;
    w0 = d[127:96];
    w1 = d[95:64];
    w2 = d[63:32];
    w3 = d[31:0];
    for (int r = 0; r < 32; r++) begin
      rk = inverse ? round_key[31-r] : round_key[r];
      nx = w0 ^ mix_data(w1 ^ w2 ^ w3 ^ rk);
      w0 = w1;
      w1 = w2;
      w2 = w3;
      w3 = nx;
    end
    return {w3, w2, w1, w0};
  endfunction

  // Result of one block under the current settings; a first block loads the IV into the chain, CBC advances it.
  function automatic sm4_pkg::res_item_t predict_block(input sm4_pkg::blk_item_t it);
    logic [127:0] din, dout;
    sm4_pkg::res_item_t r;
    din = {it.block_high, it.block_low};
    if (it.first_block) chain_word = {iv_word_hi, iv_word_lo};
    if (!cbc_on) begin
      dout = sm4_transform(din, dec_on);
    end else if (!dec_on) begin
      dout = sm4_transform(din ^ chain_word, 1'b0);
      chain_word = dout;
    end else begin
      dout = sm4_transform(din, 1'b1) ^ chain_word;
      chain_word = din;
    end
    r.result_high = dout[127:64];
    r.result_low = dout[63:0];
    r.last_out = it.last_block;
    return r;
  endfunction

  function automatic void apply_reg(input reg_idx_e idx, input logic [63:0] v);
    case (idx)
      REG_KEY_HIGH: begin
        key_word_hi = v;
        expand_key();
      end
      REG_KEY_LOW: begin
        key_word_lo = v;
        expand_key();
      end
      REG_IV_HIGH: iv_word_hi = v;
      REG_IV_LOW: iv_word_lo = v;
      REG_DECRYPT_MODE: dec_on = v[0];
      REG_CHAINING_MODE: cbc_on = v[0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display("result %0d: %s expected %h got %h", results_seen, name, want, got);
    end
  endfunction

  // Bus write: setup cycle, then access cycle until pready.
  task automatic reg_write(input reg_idx_e idx, input logic [63:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    apply_reg(idx, v);
  endtask

  task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo,
                             input logic first, input logic last);
    sm4_pkg::blk_item_t it;
    it.block_high = hi;
    it.block_low = lo;
    it.first_block = first;
    it.last_block = last;
    blocks_to_send.push_back(it);
    blocks_sent++;
  endtask

  // Waits until every queued block has been taken and answered.
  task automatic wait_idle();
    do @(negedge clk); while (blocks_taken != blocks_sent || blocks_due.size() != 0);
  endtask

  // Random 64-bit word, biased toward all zeros and all ones.
  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] rand_mode_value();
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
    return 64'($urandom_range(0, 1));
  endfunction

  // Mostly whole messages with random content, some loose blocks.
  task automatic random_traffic(input int quota);
    int n, len;
    n = 0;
    while (n < quota) begin
      if ($urandom_range(0, 6) == 0) begin
        queue_block(rand64(), rand64(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        n++;
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          queue_block(rand64(), rand64(), i == 0, i == len - 1);
        n += len;
      end
    end
  endtask

  task automatic random_setup();
    if ($urandom_range(0, 1)) reg_write(REG_KEY_HIGH, rand64());
    if ($urandom_range(0, 1)) reg_write(REG_KEY_LOW, rand64());
    if ($urandom_range(0, 1)) reg_write(REG_IV_HIGH, rand64());
    if ($urandom_range(0, 1)) reg_write(REG_IV_LOW, rand64());
    if ($urandom_range(0, 1)) reg_write(REG_DECRYPT_MODE, rand_mode_value());
    if ($urandom_range(0, 1)) reg_write(REG_CHAINING_MODE, rand_mode_value());
    if ($urandom_range(0, 7) == 0) reg_write(REG_SPARE_6, rand64());
  endtask

  // Sender: presents queued blocks, with a random gap between blocks while throttle_on is set.
  always @(posedge clk) begin : drive_blocks
    int nxt_gap;
    if (rst) begin
      blk_valid <= 1'b0;
      gap_left <= 0;
    end else if (blk_valid && !blk_stall) begin
      blocks_due.push_back(predict_block(blk));
      blocks_taken++;
      nxt_gap = throttle_on ? $urandom_range(0, 3) : 0;
      if (nxt_gap == 0 && blocks_to_send.size() > 0) begin
        blk <= blocks_to_send.pop_front();
      end else begin
        blk_valid <= 1'b0;
        gap_left <= nxt_gap;
      end
    end else if (!blk_valid) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (blocks_to_send.size() > 0) begin
        blk <= blocks_to_send.pop_front();
        blk_valid <= 1'b1;
      end
    end
  end

  // Receiver: while throttle_on is set, each taken result holds off the next one for a random spell.
  always @(posedge clk) begin : check_results
    int nxt_hold;
    sm4_pkg::res_item_t want;
    if (rst) begin
      res_stall <= 1'b0;
      hold_left <= 0;
    end else if (res_valid && !res_stall) begin
      results_seen++;
      if (blocks_due.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("result %0d: none expected, got %h", results_seen, res);
      end else begin
        want = blocks_due.pop_front();
        check_field("result_high", want.result_high, res.result_high);
        check_field("result_low", want.result_low, res.result_low);
        check_field("last_out", 64'(want.last_out), 64'(res.last_out));
      end
      nxt_hold = throttle_on ? $urandom_range(0, 3) : 0;
      hold_left <= nxt_hold;
      res_stall <= (nxt_hold != 0);
    end else if (res_valid && hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= (hold_left > 1);
    end
  end

  // Watchdog on cycles in which no item, no result and no register access goes through.
  always @(posedge clk) begin
    if (rst || (blk_valid && !blk_stall) || (res_valid && !res_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no progress for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    key_word_hi = '0;
    key_word_lo = '0;
    iv_word_hi = '0;
    iv_word_lo = '0;
    dec_on = 1'b0;
    cbc_on = 1'b0;
    chain_word = '0;
    expand_key();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // CBC with the reset key and a chain never loaded from the IV.
    reg_write(REG_CHAINING_MODE, 64'd1);
    @(negedge clk);
    queue_block('0, '0, 1'b0, 1'b0);
    queue_block('1, '1, 1'b0, 1'b1);
    wait_idle();

    // ECB encryption of the published example; a first block still loads the IV.
    reg_write(REG_KEY_HIGH, SAMPLE_TEXT[127:64]);
    reg_write(REG_KEY_LOW, SAMPLE_TEXT[63:0]);
    reg_write(REG_IV_HIGH, '1);
    reg_write(REG_IV_LOW, 64'h0123_4567_89ab_cdef);
    reg_write(REG_CHAINING_MODE, 64'd0);
    if (sm4_transform(SAMPLE_TEXT, 1'b0) !== SAMPLE_CIPHER) begin
      fault_count++;
      $display("cipher model disagrees with the published example");
    end
    @(negedge clk);
    queue_block(SAMPLE_TEXT[127:64], SAMPLE_TEXT[63:0], 1'b1, 1'b0);
    queue_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0, 1'b0);
    queue_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b0);
    queue_block('1, '0, 1'b0, 1'b1);
    wait_idle();

    // Switch to CBC mid-message: the chain still holds the IV loaded under ECB.
    reg_write(REG_CHAINING_MODE, 64'd1);
    @(negedge clk);
    queue_block('0, '1, 1'b0, 1'b0);
    queue_block(64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000, 1'b0, 1'b1);
    queue_block(SAMPLE_TEXT[127:64], SAMPLE_TEXT[63:0], 1'b1, 1'b0);
    wait_idle();

    // Direction change mid-message keeps the chain.
    reg_write(REG_DECRYPT_MODE, 64'd1);
    @(negedge clk);
    queue_block(SAMPLE_CIPHER[127:64], SAMPLE_CIPHER[63:0], 1'b0, 1'b0);
    queue_block('1, '1, 1'b0, 1'b1);
    queue_block(SAMPLE_CIPHER[127:64], SAMPLE_CIPHER[63:0], 1'b1, 1'b1);
    wait_idle();

    // ECB decryption; mode fields use bit 0 only, unmapped writes are dropped.
    reg_write(REG_CHAINING_MODE, 64'hffff_ffff_ffff_fffe);
    reg_write(REG_DECRYPT_MODE, '1);
    reg_write(REG_SPARE_6, '1);
    reg_write(REG_SPARE_7, '1);
    @(negedge clk);
    queue_block(SAMPLE_CIPHER[127:64], SAMPLE_CIPHER[63:0], 1'b0, 1'b1);
    queue_block('0, '0, 1'b1, 1'b0);
    wait_idle();

    // All-ones key, all-zero IV, CBC encryption.
    reg_write(REG_KEY_HIGH, '1);
    reg_write(REG_KEY_LOW, '1);
    reg_write(REG_IV_HIGH, '0);
    reg_write(REG_IV_LOW, '0);
    reg_write(REG_DECRYPT_MODE, 64'd2);
    reg_write(REG_CHAINING_MODE, 64'd1);
    @(negedge clk);
    queue_block('1, '1, 1'b1, 1'b0);
    queue_block('0, '0, 1'b0, 1'b1);
    wait_idle();

    // Random settings, each phase drained before the next one is set up.
    for (int phase = 0; phase < 12; phase++) begin
      random_setup();
      @(negedge clk);
      throttle_on = (phase % 3 != 2);
      random_traffic(52);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fault_count == 0 && blocks_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
